[rtl/core/out_of_order_ack_commit_tracker_macros.svh]
// Assertion macros for the commit tracker checker.
`ifndef OUT_OF_ORDER_ACK_COMMIT_TRACKER_MACROS_SVH
`define OUT_OF_ORDER_ACK_COMMIT_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OOACT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ooact same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OOACT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ooact next-cycle check failed");

`endif

[rtl/core/ooact_pkg.sv]
// Shared constants for the out-of-order ack commit tracker.
package ooact_pkg;

    localparam int OFFSET_W  = 63;   // ack offset and first expected offset
    localparam int POS_W     = 64;   // committed offset, two's complement
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ROW_BITS  = 64;   // bitmap row width
    localparam int BIT_W     = 6;    // bit index inside a row
    localparam int RUN_W     = 7;    // run length 0..64

    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STALE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BEYOND   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_EXPECTED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RESOLVED = 2'd1;

endpackage

[rtl/core/out_of_order_ack_commit_tracker.sv]
// Out-of-order ack commit tracker: circular ack bitmap with a row-wise commit walk.
// Result path: a stale or beyond-window word ends in CHECK, a mark only goes CHECK, SLOT,
//   WALK, a commit walk adds ADV and repeats WALK, ADV for each extra 64-bit bitmap row crossed.
// One word at a time: the next word is accepted after the result registers, later while
//   a result waits on out_ready.
// Reset and any register write: bitmap swept clear one row per cycle, 32 rows at default.
module out_of_order_ack_commit_tracker #(
    parameter int WINDOW_BITS = 2048
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ooact_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ooact_pkg::OFFSET_W-1:0]          cfg_data,
    // ack input channel
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [ooact_pkg::OFFSET_W-1:0]          ack_offset,
    // result channel
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    commit_advanced,
    output logic signed [ooact_pkg::POS_W-1:0]      commit_point,
    output logic [ooact_pkg::STATUS_W-1:0]          status
);

    // Bitmap geometry. The window is WINDOW_BITS slots, stored as 64-bit rows.
    localparam int ROW_COUNT = (WINDOW_BITS + ooact_pkg::ROW_BITS - 1) / ooact_pkg::ROW_BITS;
    localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int SLOT_W    = ROW_W + ooact_pkg::BIT_W;
    localparam int LAST_BITS = WINDOW_BITS - (ROW_COUNT - 1) * ooact_pkg::ROW_BITS;

    localparam logic [SLOT_W:0]               WIN_SLOT   = (SLOT_W+1)'(WINDOW_BITS);
    localparam logic [ooact_pkg::POS_W-1:0]   WIN_POS    = ooact_pkg::POS_W'(WINDOW_BITS);
    localparam logic [ROW_W-1:0]              LAST_ROW   = ROW_W'(ROW_COUNT - 1);
    localparam logic [ooact_pkg::RUN_W-1:0]   LAST_LIMIT = ooact_pkg::RUN_W'(LAST_BITS);
    localparam logic [ooact_pkg::RUN_W-1:0]   FULL_LIMIT = ooact_pkg::RUN_W'(ooact_pkg::ROW_BITS);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a word
    localparam logic [2:0] ST_CHECK = 3'd1;  // window compare
    localparam logic [2:0] ST_SLOT  = 3'd2;  // slot address, row read
    localparam logic [2:0] ST_WALK  = 3'd3;  // mark bit and/or find run, row write
    localparam logic [2:0] ST_ADV   = 3'd4;  // advance committed point and head
    localparam logic [2:0] ST_HOLD  = 3'd5;  // result waits for the output register

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [2:0]                       state_reg,      state_next;
    logic [ooact_pkg::OFFSET_W-1:0]   first_exp_reg,  first_exp_next;
    logic                             start_res_reg,  start_res_next;
    logic                             base_res_reg,   base_res_next;
    logic [ooact_pkg::POS_W-1:0]      committed_reg,  committed_next;
    logic [SLOT_W-1:0]                head_reg,       head_next;    // slot of committed+1
    logic [ooact_pkg::OFFSET_W-1:0]   off_reg,        off_next;
    logic [SLOT_W-1:0]                diff_reg,       diff_next;    // offset - (committed+1)
    logic [SLOT_W-1:0]                slot_reg,       slot_next;
    logic [ROW_W-1:0]                 row_reg,        row_next;     // row held in rdata_reg
    logic                             mark_reg,       mark_next;    // set the ack bit in WALK
    logic                             walk_reg,       walk_next;    // run the commit walk
    logic [ooact_pkg::RUN_W-1:0]      run_reg,        run_next;
    logic                             end_reg,        end_next;     // run hit the row end
    logic                             adv_reg,        adv_next;
    logic [ooact_pkg::STATUS_W-1:0]   status_reg,     status_next;
    logic                             clr_active_reg, clr_active_next;
    logic [ROW_W-1:0]                 clr_idx_reg,    clr_idx_next;
    logic                             out_valid_reg,  out_valid_next;
    logic                             out_adv_reg,    out_adv_next;
    logic [ooact_pkg::POS_W-1:0]      out_pos_reg,    out_pos_next;
    logic [ooact_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;

    // Bitmap memory: one write port, one registered read port.
    logic [ooact_pkg::ROW_BITS-1:0]   bitmap_mem [ROW_COUNT];
    logic [ooact_pkg::ROW_BITS-1:0]   rdata_reg;
    logic                             mem_we;
    logic [ROW_W-1:0]                 mem_waddr;
    logic [ooact_pkg::ROW_BITS-1:0]   mem_wdata;
    logic                             mem_re;
    logic [ROW_W-1:0]                 mem_raddr;

    // ------------------------------------------------------------------
    // Shared run-length unit: from the head bit of the current row, count
    // contiguous set bits and clear them. Used once per row of the walk.
    // ------------------------------------------------------------------
    logic [ooact_pkg::BIT_W-1:0]      head_bit;
    logic [ooact_pkg::ROW_BITS-1:0]   row_in;
    logic [ooact_pkg::ROW_BITS-1:0]   row_shift;
    logic [ooact_pkg::ROW_BITS-1:0]   row_zeros;
    logic [ooact_pkg::ROW_BITS-1:0]   lowest_zero;
    logic [ooact_pkg::RUN_W-1:0]      run_len;
    logic [ooact_pkg::ROW_BITS:0]     run_ones;
    logic [ooact_pkg::ROW_BITS-1:0]   row_cleared;
    logic [ooact_pkg::RUN_W-1:0]      row_limit;
    logic                             run_at_end;

    assign head_bit  = head_reg[ooact_pkg::BIT_W-1:0];
    assign row_in    = rdata_reg
                     | (mark_reg ? ({{(ooact_pkg::ROW_BITS-1){1'b0}}, 1'b1}
                                     << slot_reg[ooact_pkg::BIT_W-1:0])
                                 : '0);
    assign row_shift   = row_in >> head_bit;
    assign row_zeros   = ~row_shift;
    assign lowest_zero = row_zeros & (~row_zeros + 1'b1);

    always_comb
    begin
        run_len = '0;
        if (row_zeros == '0)
        begin
            run_len = FULL_LIMIT;
        end
        else
        begin
            for (int j = 0; j < ooact_pkg::ROW_BITS; j++)
            begin
                if (lowest_zero[j])
                begin
                    run_len = run_len | ooact_pkg::RUN_W'(j);
                end
            end
        end
    end

    assign run_ones    = ((ooact_pkg::ROW_BITS+1)'(1) << run_len) - 1'b1;
    assign row_cleared = row_in & ~(run_ones[ooact_pkg::ROW_BITS-1:0] << head_bit);
    // last row may be partial when the window is not a multiple of 64
    assign row_limit   = (row_reg == LAST_ROW) ? LAST_LIMIT : FULL_LIMIT;
    assign run_at_end  = (ooact_pkg::RUN_W'(head_bit) + run_len) == row_limit;

    // ------------------------------------------------------------------
    // Window check: off + ~committed = off - committed - 1 with a carry that
    // says off >= committed + 1. When committed is all ones nothing is stale.
    // ------------------------------------------------------------------
    logic [ooact_pkg::POS_W:0]        chk_sum;
    logic                             chk_stale;
    logic                             chk_beyond;

    assign chk_sum    = {2'b00, off_reg} + {1'b0, ~committed_reg};
    assign chk_stale  = !chk_sum[ooact_pkg::POS_W] && (committed_reg != '1);
    assign chk_beyond = !chk_stale && (chk_sum[ooact_pkg::POS_W-1:0] >= WIN_POS);

    // Physical slot = head + distance, wrapped once at the window size.
    logic [SLOT_W:0]                  slot_sum;
    logic [SLOT_W:0]                  slot_wrap;
    logic [SLOT_W:0]                  head_sum;

    assign slot_sum  = {1'b0, head_reg} + {1'b0, diff_reg};
    assign slot_wrap = (slot_sum >= WIN_SLOT) ? (slot_sum - WIN_SLOT) : slot_sum;
    assign head_sum  = {1'b0, head_reg} + (SLOT_W+1)'(run_reg);

    logic                             cfg_hit;
    logic                             out_free;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == ooact_pkg::CFG_FIRST_EXPECTED
                                  || cfg_index == ooact_pkg::CFG_START_RESOLVED);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && !clr_active_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        logic finish;

        finish          = 1'b0;
        state_next      = state_reg;
        first_exp_next  = first_exp_reg;
        start_res_next  = start_res_reg;
        base_res_next   = base_res_reg;
        committed_next  = committed_reg;
        head_next       = head_reg;
        off_next        = off_reg;
        diff_next       = diff_reg;
        slot_next       = slot_reg;
        row_next        = row_reg;
        mark_next       = mark_reg;
        walk_next       = walk_reg;
        run_next        = run_reg;
        end_next        = end_reg;
        adv_next        = adv_reg;
        status_next     = status_reg;
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_adv_next    = out_adv_reg;
        out_pos_next    = out_pos_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = row_reg;
        mem_wdata       = row_in;
        mem_re          = 1'b0;
        mem_raddr       = row_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    off_next = ack_offset;
                    adv_next = 1'b0;
                    // unresolved start: this word becomes the base
                    if (!base_res_reg)
                    begin
                        base_res_next  = 1'b1;
                        committed_next = {1'b0, ack_offset} - 1'b1;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                diff_next = chk_sum[SLOT_W-1:0];
                walk_next = (chk_sum[SLOT_W-1:0] == '0);
                if (chk_stale)
                begin
                    status_next = ooact_pkg::STATUS_STALE;
                    finish      = 1'b1;
                end
                else if (chk_beyond)
                begin
                    status_next = ooact_pkg::STATUS_BEYOND;
                    finish      = 1'b1;
                end
                else
                begin
                    status_next = ooact_pkg::STATUS_ACCEPTED;
                    state_next  = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                slot_next  = slot_wrap[SLOT_W-1:0];
                row_next   = slot_wrap[SLOT_W-1:ooact_pkg::BIT_W];
                mem_re     = 1'b1;
                mem_raddr  = slot_wrap[SLOT_W-1:ooact_pkg::BIT_W];
                mark_next  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // acks away from the head only set their bit; the head bit is
                // always clear between words, so no walk can start there
                mem_we    = 1'b1;
                mem_waddr = row_reg;
                if (walk_reg)
                begin
                    mem_wdata  = row_cleared;
                    run_next   = run_len;
                    end_next   = run_at_end;
                    state_next = ST_ADV;
                end
                else
                begin
                    mem_wdata = row_in;
                    finish    = 1'b1;
                end
            end
            ST_ADV:
            begin
                committed_next = committed_reg + ooact_pkg::POS_W'(run_reg);
                head_next      = (head_sum == WIN_SLOT) ? '0 : head_sum[SLOT_W-1:0];
                if (run_reg != '0)
                begin
                    adv_next = 1'b1;
                end
                if (end_reg)
                begin
                    // run reached the row end: continue in the next row
                    row_next   = head_next[SLOT_W-1:ooact_pkg::BIT_W];
                    mem_re     = 1'b1;
                    mem_raddr  = head_next[SLOT_W-1:ooact_pkg::BIT_W];
                    mark_next  = 1'b0;
                    walk_next  = 1'b1;
                    state_next = ST_WALK;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_adv_next    = adv_reg;
                    out_pos_next    = committed_reg;
                    out_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_adv_next    = adv_next;
                out_pos_next    = committed_next;
                out_status_next = status_next;
                state_next      = ST_IDLE;
            end
            else
            begin
                state_next = ST_HOLD;
            end
        end

        // bitmap clearing sweep, one row per cycle
        if (clr_active_reg)
        begin
            mem_we       = 1'b1;
            mem_waddr    = clr_idx_reg;
            mem_wdata    = '0;
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_ROW)
            begin
                clr_active_next = 1'b0;
            end
        end

        // register write reloads the whole tracker state
        if (cfg_hit)
        begin
            if (cfg_index == ooact_pkg::CFG_FIRST_EXPECTED)
            begin
                first_exp_next = cfg_data;
            end
            else
            begin
                start_res_next = cfg_data[0];
            end
            committed_next  = {1'b0, first_exp_next} - 1'b1;
            base_res_next   = start_res_next;
            head_next       = '0;
            clr_active_next = 1'b1;
            clr_idx_next    = '0;
            state_next      = ST_IDLE;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_exp_reg  <= '0;
            start_res_reg  <= 1'b1;
            base_res_reg   <= 1'b1;
            committed_reg  <= '1;
            head_reg       <= '0;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_exp_reg  <= first_exp_next;
            start_res_reg  <= start_res_next;
            base_res_reg   <= base_res_next;
            committed_reg  <= committed_next;
            head_reg       <= head_next;
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        diff_reg       <= diff_next;
        slot_reg       <= slot_next;
        row_reg        <= row_next;
        mark_reg       <= mark_next;
        walk_reg       <= walk_next;
        run_reg        <= run_next;
        end_reg        <= end_next;
        adv_reg        <= adv_next;
        status_reg     <= status_next;
        out_adv_reg    <= out_adv_next;
        out_pos_reg    <= out_pos_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= bitmap_mem[mem_raddr];
        end
    end

    assign out_valid       = out_valid_reg;
    assign commit_advanced = out_adv_reg;
    assign commit_point    = out_pos_reg;
    assign status          = out_status_reg;

endmodule

[rtl/core/ooact_checker.sv]
// Port-level checker for the commit tracker, bound to the top level.
`include "out_of_order_ack_commit_tracker_macros.svh"

module ooact_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [ooact_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 commit_advanced,
    input logic signed [ooact_pkg::POS_W-1:0]   commit_point,
    input logic [ooact_pkg::STATUS_W-1:0]       status
);

    logic                                              status_known;
    logic                                              cfg_reload;
    logic [ooact_pkg::POS_W+ooact_pkg::STATUS_W:0]     out_word;

    assign status_known = (status == ooact_pkg::STATUS_ACCEPTED)
                       || (status == ooact_pkg::STATUS_STALE)
                       || (status == ooact_pkg::STATUS_BEYOND);
    assign cfg_reload   = cfg_valid && cfg_ready
                       && (cfg_index == ooact_pkg::CFG_FIRST_EXPECTED
                        || cfg_index == ooact_pkg::CFG_START_RESOLVED);
    assign out_word     = {commit_advanced, commit_point, status};

    // only the three defined status codes leave the block
    `OOACT_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, status_known)

    // an ignored word never moves the commit point
    `OOACT_ASSERT_NOW(a_adv_accepted, clk, rst_n, out_valid && commit_advanced, status == ooact_pkg::STATUS_ACCEPTED)

    // one word in flight at a time
    `OOACT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a register write starts the bitmap sweep, input held off
    `OOACT_ASSERT_NEXT(a_cfg_sweep, clk, rst_n, cfg_reload, !in_ready)

    // stalled result holds
    `OOACT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind out_of_order_ack_commit_tracker ooact_checker u_ooact_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .commit_advanced  (commit_advanced),
    .commit_point     (commit_point),
    .status           (status)
);

[dv/out_of_order_ack_commit_tracker_test.sv]
// Self-checking testbench for the out-of-order ack commit tracker.
`timescale 1ns / 1ps

module out_of_order_ack_commit_tracker_test;

    localparam int WINDOW_BITS = 2048;
    localparam int SLOT_W      = $clog2(WINDOW_BITS);
    localparam int CYCLE_LIMIT = 1000000;
    // Longest commit walk crosses every bitmap row.
    localparam int TAIL_CYCLES = 80;

    localparam logic [ooact_pkg::POS_W-1:0] TOP_OFFSET = 64'h7FFF_FFFF_FFFF_FFFF;

    // Indexes past the register list; a write there must change nothing.
    localparam logic [ooact_pkg::CFG_IDX_W-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [ooact_pkg::CFG_IDX_W-1:0] CFG_SPARE_HIGH = 2'd3;

    // One result word as the tracker should report it.
    typedef struct packed {
        logic                           advanced;
        logic [ooact_pkg::POS_W-1:0]    pos;
        logic [ooact_pkg::STATUS_W-1:0] code;
    } commit_report_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                                  clk        = 1'b0;
    logic                                  rst_n      = 1'b0;
    logic                                  cfg_valid  = 1'b0;
    logic                                  cfg_ready;
    logic [ooact_pkg::CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [ooact_pkg::OFFSET_W-1:0]        cfg_data   = '0;
    logic                                  in_valid   = 1'b0;
    logic                                  in_ready;
    logic [ooact_pkg::OFFSET_W-1:0]        ack_offset = '0;
    logic                                  out_valid;
    logic                                  out_ready  = 1'b0;
    logic                                  commit_advanced;
    logic signed [ooact_pkg::POS_W-1:0]    commit_point;
    logic [ooact_pkg::STATUS_W-1:0]        status;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    out_of_order_ack_commit_tracker #(
        .WINDOW_BITS(WINDOW_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .ack_offset       (ack_offset),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .commit_advanced  (commit_advanced),
        .commit_point     (commit_point),
        .status           (status)
    );

    // ------------------------------------------------------------------
    // Shadow tracker: registers, ack bitmap and committed position
    // ------------------------------------------------------------------
    logic [ooact_pkg::OFFSET_W-1:0] first_expected;
    logic                           start_known;
    logic [WINDOW_BITS-1:0]         ack_window;
    logic [ooact_pkg::POS_W-1:0]    commit_pos;
    logic                           base_known;

    commit_report_t commit_reports_due[$];

    int  items_sent      = 0;
    int  reports_checked = 0;
    int  advances_seen   = 0;
    int  stale_seen      = 0;
    int  beyond_seen     = 0;
    int  cfg_writes      = 0;
    int  mismatches      = 0;
    int  cycle_count     = 0;
    int  stall_left      = 0;
    // When set, neither side idles.
    bit  quiet           = 1'b0;

    // Any register write reloads the whole tracker state.
    function automatic void reload_tracker();
        ack_window = '0;
        commit_pos = {1'b0, first_expected} - 64'd1;
        base_known = start_known;
    endfunction

    function automatic void apply_register(
        input logic [ooact_pkg::CFG_IDX_W-1:0] index,
        input logic [ooact_pkg::OFFSET_W-1:0]  value);
        case (index)
            ooact_pkg::CFG_FIRST_EXPECTED:
            begin
                first_expected = value;
                reload_tracker();
            end
            ooact_pkg::CFG_START_RESOLVED:
            begin
                start_known = value[0];
                reload_tracker();
            end
            default: ;
        endcase
    endfunction

    // Mark one ack and walk the committed point over the contiguous run.
    function automatic commit_report_t track_ack(
        input logic [ooact_pkg::OFFSET_W-1:0] offset);
        commit_report_t              report;
        logic [ooact_pkg::POS_W-1:0] offset_wide;
        logic [ooact_pkg::POS_W-1:0] prior;
        logic [ooact_pkg::POS_W-1:0] next_pos;
        logic [ooact_pkg::POS_W-1:0] probe;
        int                          steps;
        offset_wide = {1'b0, offset};
        // unresolved start: the first ack becomes the base
        if (!base_known)
        begin
            base_known = 1'b1;
            commit_pos = offset_wide - 64'd1;
        end
        prior       = commit_pos;
        next_pos    = commit_pos + 64'd1;
        report.code = ooact_pkg::STATUS_ACCEPTED;
        if (offset_wide < next_pos)
            report.code = ooact_pkg::STATUS_STALE;
        else if (offset_wide - next_pos >= 64'(WINDOW_BITS))
            report.code = ooact_pkg::STATUS_BEYOND;
        else
        begin
            ack_window[offset_wide[SLOT_W-1:0]] = 1'b1;
            steps = 0;
            while (steps < WINDOW_BITS)
            begin
                probe = commit_pos + 64'd1;
                if (!ack_window[probe[SLOT_W-1:0]])
                    break;
                ack_window[probe[SLOT_W-1:0]] = 1'b0;
                commit_pos = probe;
                steps++;
            end
        end
        report.advanced = (commit_pos != prior);
        report.pos      = commit_pos;
        return report;
    endfunction

    function automatic logic [ooact_pkg::POS_W-1:0] rand_wide();
        logic [ooact_pkg::POS_W-1:0] value;
        value = {$urandom, $urandom};
        return value;
    endfunction

    // First expected offset for a random phase: extremes, small, near the top or random.
    function automatic logic [ooact_pkg::POS_W-1:0] pick_first_expected();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return TOP_OFFSET;
            2:       return TOP_OFFSET - $urandom_range(0, 3000);
            3:       return $urandom_range(0, 4095);
            default: return rand_wide();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what,
                                 input logic [ooact_pkg::POS_W-1:0] got,
                                 input logic [ooact_pkg::POS_W-1:0] want);
        $display("[%0t] result %0d: %s got %h, expected %h",
                 $realtime, reports_checked, what, got, want);
        mismatches++;
    endtask

    // Each accepted result word is checked against the oldest expected report.
    always @(posedge clk)
    begin : check_commit_reports
        commit_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (commit_reports_due.size() == 0)
                flag_mismatch("unexpected result word, commit_point",
                              commit_point, '0);
            else
            begin
                want = commit_reports_due.pop_front();
                if (commit_advanced !== want.advanced)
                    flag_mismatch("commit_advanced", commit_advanced, want.advanced);
                if (commit_point !== want.pos)
                    flag_mismatch("commit_point", commit_point, want.pos);
                if (status !== want.code)
                    flag_mismatch("status", status, want.code);
                if (want.advanced)
                    advances_seen++;
                if (want.code == ooact_pkg::STATUS_STALE)
                    stale_seen++;
                if (want.code == ooact_pkg::STATUS_BEYOND)
                    beyond_seen++;
            end
            reports_checked++;
        end
    end

    // Result side: random stall bursts unless quiet.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] watchdog expired", $realtime);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (all entered and left on a rising edge)
    // ------------------------------------------------------------------

    // Send one ack word; valid stays up into the next word unless a gap is drawn.
    task automatic send_ack(input logic [ooact_pkg::POS_W-1:0] offset_wide);
        in_valid   <= 1'b1;
        ack_offset <= offset_wide[ooact_pkg::OFFSET_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        commit_reports_due.push_back(track_ack(offset_wide[ooact_pkg::OFFSET_W-1:0]));
        items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Hold the sender off until every expected report is in, then let the
    // block settle.
    task automatic settle_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (commit_reports_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Register writes only happen with the tracker idle.
    task automatic write_register(input logic [ooact_pkg::CFG_IDX_W-1:0] index,
                                  input logic [ooact_pkg::POS_W-1:0]     value);
        settle_results();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[ooact_pkg::OFFSET_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(index, value[ooact_pkg::OFFSET_W-1:0]);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random noise between run words: stale, beyond, wild, duplicate, window edge.
    task automatic send_noise(ref logic [ooact_pkg::POS_W-1:0] sent[$]);
        case ($urandom_range(0, 23))
            0, 1: send_ack(commit_pos - $urandom_range(0, 3000));
            2:    send_ack(commit_pos + 64'd2049 + $urandom_range(0, 5000));
            3:    send_ack(rand_wide());
            4:
            begin
                if (sent.size() != 0)
                    send_ack(sent[$urandom_range(0, sent.size() - 1)]);
            end
            5:    send_ack(commit_pos + 64'(WINDOW_BITS));
            default: ;
        endcase
    endtask

    // A run of consecutive offsets from the committed point, shuffled. With a
    // hole, the first offset is held back to the end so the walk covers the run.
    task automatic send_shuffled_run(input int run_len, input bit with_hole);
        logic [ooact_pkg::POS_W-1:0] run_base;
        logic [ooact_pkg::POS_W-1:0] sent[$];
        int                          order[$];
        int                          i;
        int                          pick;
        int                          swap;
        run_base = commit_pos + 64'd1;
        for (i = int'(with_hole); i < run_len; i++)
            order.push_back(i);
        for (i = order.size() - 1; i > 0; i--)
        begin
            pick        = $urandom_range(0, i);
            swap        = order[i];
            order[i]    = order[pick];
            order[pick] = swap;
        end
        for (i = 0; i < order.size(); i++)
        begin
            send_noise(sent);
            send_ack(run_base + order[i]);
            sent.push_back(run_base + order[i]);
        end
        if (with_hole)
            send_ack(run_base);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: nothing committed, window 0..2047.
    task automatic test_reset_window_edges();
        send_ack(64'd0);        // commits 0
        send_ack(64'd0);        // now stale
        send_ack(64'd2049);     // one past the window
        send_ack(64'd2048);     // last slot of the window
        send_ack(64'd3);
        send_ack(64'd3);        // duplicate, no effect
        send_ack(64'd2);
        send_ack(64'd1);        // fills the gap, walk to 3
        send_ack(TOP_OFFSET);   // far beyond
    endtask

    // Unresolved start: the first ack sets the base and commits at once.
    task automatic test_unresolved_base();
        write_register(ooact_pkg::CFG_START_RESOLVED, rand_wide() & ~64'd1);
        send_ack(TOP_OFFSET);       // top of range, nothing after it fits
        send_ack(64'd0);
        send_ack(TOP_OFFSET);
        write_register(ooact_pkg::CFG_FIRST_EXPECTED, '0);
        send_ack(64'd5);
    endtask

    // Register extremes and writes to the spare indexes.
    task automatic test_register_extremes();
        write_register(ooact_pkg::CFG_START_RESOLVED, rand_wide() | 64'd1);
        write_register(ooact_pkg::CFG_FIRST_EXPECTED, TOP_OFFSET);
        send_ack(TOP_OFFSET);
        send_ack(TOP_OFFSET - 64'd1);
        write_register(CFG_SPARE_LOW, rand_wide());
        send_ack(64'd0);
        write_register(CFG_SPARE_HIGH, '1);
        write_register(ooact_pkg::CFG_FIRST_EXPECTED, TOP_OFFSET - 64'd2047);
        send_ack(TOP_OFFSET);               // far edge of the window
        send_ack(TOP_OFFSET - 64'd2047);    // commits one
    endtask

    // Main random part: phases of shuffled runs with fresh register settings.
    task automatic test_shuffled_runs(input int phases, input int per_phase);
        int phase;
        int phase_end;
        for (phase = 0; phase < phases; phase++)
        begin
            if ($urandom_range(0, 2) == 0)
                write_register(ooact_pkg::CFG_START_RESOLVED, rand_wide());
            write_register(ooact_pkg::CFG_FIRST_EXPECTED, pick_first_expected());
            phase_end = items_sent + per_phase;
            while (items_sent < phase_end)
            begin
                quiet = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) == 0)
                    send_shuffled_run($urandom_range(41, 200), $urandom_range(0, 1));
                else
                    send_shuffled_run($urandom_range(1, 40), $urandom_range(0, 2) == 0);
            end
        end
        quiet = 1'b0;
    endtask

    // One long held-back run so a single ack drives the walk across many rows.
    task automatic test_long_walk();
        logic [ooact_pkg::POS_W-1:0] walk_base;
        write_register(ooact_pkg::CFG_START_RESOLVED, 64'd1);
        write_register(ooact_pkg::CFG_FIRST_EXPECTED, $urandom_range(0, 100000));
        walk_base = commit_pos + 64'd1;
        send_ack(walk_base + 64'(WINDOW_BITS - 1));
        send_shuffled_run(320, 1'b1);
    endtask

    // Sender waits for every report between runs.
    task automatic test_commit_pause();
        repeat (4)
        begin
            send_shuffled_run($urandom_range(5, 30), 1'b1);
            settle_results();
        end
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_back_to_back(input int count);
        int stop_at;
        quiet   = 1'b1;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_shuffled_run($urandom_range(1, 60), $urandom_range(0, 1));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        first_expected = '0;
        start_known    = 1'b1;
        reload_tracker();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_window_edges();
        test_unresolved_base();
        test_register_extremes();
        test_shuffled_runs(7, 190);
        test_long_walk();
        test_commit_pause();
        test_back_to_back(300);

        settle_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d ack words, %0d result words over %0d register writes.",
                 items_sent, reports_checked, cfg_writes);
        $display("Commit advances %0d, stale acks %0d, beyond-window acks %0d.",
                 advances_seen, stale_seen, beyond_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ooact_pkg.sv
rtl/core/out_of_order_ack_commit_tracker.sv
rtl/core/ooact_checker.sv
dv/out_of_order_ack_commit_tracker_test.sv
